[hdl/fnst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy name scorer package
// Shared payload types, control structs, command codes and scoring constants.
// ----------------------------------------------------------------------------
package fnst_pkg;

	localparam int unsigned MAX_QUERY_DEF    = 64;
	localparam int unsigned TOP_SLOTS_DEF    = 32;
	localparam int unsigned MAX_NAME_LEN_DEF = 255;

	localparam int unsigned ID_W    = 16;
	localparam int unsigned SCORE_W = 10;
	localparam int unsigned CALC_W  = 18;

	localparam logic [SCORE_W:0] BONUS_EXACT  = 11'd1000;
	localparam logic [SCORE_W:0] BONUS_PREFIX = 11'd300;
	localparam logic [SCORE_W:0] BONUS_SUBSTR = 11'd180;
	localparam logic [SCORE_W:0] BONUS_SUBSEQ = 11'd100;

	typedef enum logic [2:0] {
		CMD_NEW_QUERY  = 3'd0,
		CMD_QUERY_CHAR = 3'd1,
		CMD_NAME_CHAR  = 3'd2,
		CMD_END_NAME   = 3'd3,
		CMD_EMIT       = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_INS_WRITE,
		ST_SORT_A,
		ST_SORT_B,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]      command;
		logic [7:0]      character;
		logic [ID_W-1:0] entry_id;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    result_id;
		logic [SCORE_W-1:0] result_score;
		logic               slot_valid;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} slot_t;

	typedef struct packed {
		logic       step;
		logic       restart;
		logic [7:0] character;
	} qcell_ctl_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} scell_ctl_t;

	function automatic logic [7:0] lower_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

endpackage

[hdl/fnst_query_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query cell
// Holds one query character and one bit of the substring shift-and vector.
// ----------------------------------------------------------------------------
module fnst_query_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  fnst_pkg::qcell_ctl_t ctl,
	input  logic               load,
	input  logic               active,
	input  logic               prev_vec,
	output logic               vec,
	output logic               eq,
	output logic               hit
);
	import fnst_pkg::*;

	logic [7:0] char_q;
	logic       vec_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ctl.character;
		end
	end

	assign eq  = (char_q == ctl.character);
	assign hit = prev_vec && eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q <= 1'b0;
		end else if (ctl.restart) begin
			vec_q <= 1'b0;
		end else if (ctl.step) begin
			vec_q <= active && hit;
		end
	end

	assign vec = vec_q;

endmodule

[hdl/fnst_slot_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot cell
// One entry of the ranking ring; passes its entry toward the head on a shift.
// ----------------------------------------------------------------------------
module fnst_slot_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fnst_pkg::scell_ctl_t ctl,
	input  logic                 active,
	input  logic                 is_last,
	input  fnst_pkg::slot_t      next_entry,
	input  fnst_pkg::slot_t      tail,
	output fnst_pkg::slot_t      entry
);
	import fnst_pkg::*;

	slot_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.clear) begin
			entry_q <= '0;
		end else if (ctl.shift && active) begin
			entry_q <= is_last ? tail : next_entry;
		end
	end

	assign entry = entry_q;

endmodule

[hdl/fuzzy_name_scorer_top_k.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy name scorer with top-K table
// Scores streamed names against a loaded query and ranks the best of them.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. Query and name
// character commands, as well as a new query, never raise busy, so a name
// streams at one character per clock. End of name raises no busy when the score
// is not positive or no slot is in use; otherwise the block rotates the ring of
// slot cells once to scan for a duplicate id and the lowest slot, and once more
// when the entry is written in. Emit runs an exchange sort when more than one
// slot is in use and then shows one result per cycle on result with
// result_strobe high; with no slot in use a single empty result marked last
// appears in the cycle after acceptance. Every comparison is made at the head
// of the slot ring, through which every slot rotates once per pass. The
// receiver cannot stall the block: each result is valid for exactly one
// cycle.
// ----------------------------------------------------------------------------
module fuzzy_name_scorer_top_k #(
	parameter int unsigned MAX_QUERY    = fnst_pkg::MAX_QUERY_DEF,
	parameter int unsigned TOP_SLOTS    = fnst_pkg::TOP_SLOTS_DEF,
	parameter int unsigned MAX_NAME_LEN = fnst_pkg::MAX_NAME_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fnst_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_data,
	output fnst_pkg::out_item_t result,
	output logic                result_strobe
);
	import fnst_pkg::*;

	// Widths that follow from the parameters.
	localparam int unsigned QLW = $clog2(MAX_QUERY + 1);
	localparam int unsigned IW  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
	localparam int unsigned NLW = $clog2(MAX_NAME_LEN + 1);
	localparam int unsigned SLW = $clog2(TOP_SLOTS + 1);

	state_t state_q, state_d;

	logic [5:0]         top_count_q;
	logic [QLW-1:0]     qlen_q;
	logic [NLW-1:0]     nl_q;
	logic               prefix_q;
	logic               found_q;
	logic [QLW-1:0]     sp_q;
	logic [SLW-1:0]     n_q, k_q, i_q, worst_q;
	logic [ID_W-1:0]    new_id_q;
	logic [SCORE_W-1:0] new_score_q, worst_score_q;
	logic               dup_q;
	slot_t              carry_q;
	out_item_t          result_q;
	logic               strobe_q;

	logic               accept;
	logic [7:0]         chr;
	logic [SLW-1:0]     n_now;
	logic               k_end;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign chr    = lower_byte(item.character);
	assign k_end  = (k_q == n_q - SLW'(1));

	// Slots in use, capped at the number of cells that exist.
	always_comb begin
		if ({1'b0, top_count_q} >= 7'(TOP_SLOTS)) begin
			n_now = SLW'(TOP_SLOTS);
		end else begin
			n_now = SLW'(top_count_q);
		end
	end

	// ---------------------------------------------------------------- query row
	qcell_ctl_t           qctl;
	logic [MAX_QUERY-1:0] q_vec, q_eq, q_hit, q_load, q_active;
	logic                 is_new, is_qchar, is_nchar, is_end, is_emit;

	assign is_new   = accept && (item.command == CMD_NEW_QUERY);
	assign is_qchar = accept && (item.command == CMD_QUERY_CHAR);
	assign is_nchar = accept && (item.command == CMD_NAME_CHAR);
	assign is_end   = accept && (item.command == CMD_END_NAME);
	assign is_emit  = accept && (item.command == CMD_EMIT);

	assign qctl.step      = is_nchar;
	assign qctl.restart   = is_new || is_qchar || is_end;
	assign qctl.character = chr;

	genvar gq;
	generate
		for (gq = 0; gq < MAX_QUERY; gq++) begin : g_query
			logic prev;
			if (gq == 0) begin : g_head
				assign prev = 1'b1;
			end else begin : g_body
				assign prev = q_vec[gq-1];
			end
			assign q_load[gq]   = is_qchar && (qlen_q == QLW'(gq));
			assign q_active[gq] = (QLW'(gq) < qlen_q);
			fnst_query_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (qctl),
				.load     (q_load[gq]),
				.active   (q_active[gq]),
				.prev_vec (prev),
				.vec      (q_vec[gq]),
				.eq       (q_eq[gq]),
				.hit      (q_hit[gq])
			);
		end
	endgenerate

	// Per-character tracking of the prefix, substring and subsequence tests.
	logic           nl_lt_q, prefix_miss, tail_hit, sp_adv;
	logic [QLW-1:0] qlen_m1;

	assign qlen_m1     = qlen_q - QLW'(1);
	assign nl_lt_q     = ({{(CALC_W-NLW){1'b0}}, nl_q} < CALC_W'(qlen_q));
	assign prefix_miss = nl_lt_q && !q_eq[nl_q[IW-1:0]];
	assign tail_hit    = (qlen_q != '0) && q_hit[qlen_m1[IW-1:0]];
	assign sp_adv      = (sp_q < qlen_q) && q_eq[sp_q[IW-1:0]];

	// Score of the name that ends now.
	logic [CALC_W-1:0]        nl_x, q_x, diff;
	logic [SCORE_W:0]         bonus;
	logic signed [CALC_W-1:0] score;
	logic                     score_pos;

	always_comb begin
		nl_x = CALC_W'(nl_q);
		q_x  = CALC_W'(qlen_q);
		diff = (nl_x >= q_x) ? (nl_x - q_x) : (q_x - nl_x);
		if (prefix_q && nl_x == q_x) begin
			bonus = BONUS_EXACT;
		end else if (prefix_q && nl_x >= q_x) begin
			bonus = BONUS_PREFIX;
		end else if (found_q) begin
			bonus = BONUS_SUBSTR;
		end else if (sp_q == qlen_q) begin
			bonus = BONUS_SUBSEQ;
		end else begin
			bonus = '0;
		end
		if (qlen_q == '0) begin
			score = CALC_W'(1);
		end else begin
			score = $signed(CALC_W'(bonus)) - $signed(diff);
		end
		score_pos = (score > 0);
	end

	// ---------------------------------------------------------------- slot ring
	scell_ctl_t sctl;
	slot_t      cells [TOP_SLOTS];
	slot_t      head, tail;
	logic       head_less, head_dup, head_more;

	assign head      = cells[0];
	assign head_dup  = (head.score != '0) && (head.id == new_id_q);
	assign head_less = (head.score < worst_score_q);
	assign head_more = (head.score > carry_q.score);

	genvar gs;
	generate
		for (gs = 0; gs < TOP_SLOTS; gs++) begin : g_slot
			slot_t nxt;
			if (gs == TOP_SLOTS - 1) begin : g_end
				assign nxt = tail;
			end else begin : g_mid
				assign nxt = cells[gs+1];
			end
			fnst_slot_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (sctl),
				.active     (SLW'(gs) < n_q),
				.is_last    (SLW'(gs) == n_q - SLW'(1)),
				.next_entry (nxt),
				.tail       (tail),
				.entry      (cells[gs])
			);
		end
	endgenerate

	// Scan results including the entry at the head this cycle.
	logic               scan_dup;
	logic [SCORE_W-1:0] scan_worst;
	logic               write_need;

	assign scan_dup   = dup_q || head_dup;
	assign scan_worst = (k_q == '0 || head_less) ? head.score : worst_score_q;
	assign write_need = !scan_dup && (new_score_q > scan_worst);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_end && score_pos && n_now != '0) begin
					state_d = ST_INS_SCAN;
				end else if (is_emit && n_now == SLW'(1)) begin
					state_d = ST_EMIT;
				end else if (is_emit && n_now > SLW'(1)) begin
					state_d = ST_SORT_A;
				end
			end
			ST_INS_SCAN: begin
				if (k_end) begin
					state_d = write_need ? ST_INS_WRITE : ST_IDLE;
				end
			end
			ST_INS_WRITE: begin
				if (k_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_SORT_A: begin
				if (k_end) begin
					state_d = ST_SORT_B;
				end
			end
			ST_SORT_B: begin
				if (k_end) begin
					state_d = (i_q + SLW'(1) == n_q - SLW'(1)) ? ST_EMIT : ST_SORT_A;
				end
			end
			ST_EMIT: begin
				if (k_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- ring control
	always_comb begin
		sctl.clear = is_new;
		sctl.shift = 1'b0;
		tail       = head;
		case (state_q)
			ST_IDLE: begin
				sctl.shift = 1'b0;
			end
			ST_INS_SCAN: begin
				sctl.shift = 1'b1;
			end
			ST_INS_WRITE: begin
				sctl.shift = 1'b1;
				if (k_q == worst_q) begin
					tail.id    = new_id_q;
					tail.score = new_score_q;
				end
			end
			ST_SORT_A: begin
				sctl.shift = 1'b1;
				if (k_q > i_q && head_more) begin
					tail = carry_q;
				end
			end
			ST_SORT_B: begin
				sctl.shift = 1'b1;
				if (k_q == i_q) begin
					tail = carry_q;
				end
			end
			ST_EMIT: begin
				sctl.shift = 1'b1;
			end
			default: begin
				sctl.shift = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_count_q <= '0;
			qlen_q      <= '0;
			nl_q        <= '0;
			prefix_q    <= 1'b1;
			found_q     <= 1'b0;
			sp_q        <= '0;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			strobe_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (cfg_we) begin
				top_count_q <= cfg_data;
			end
			if (qctl.restart) begin
				nl_q     <= '0;
				prefix_q <= 1'b1;
				found_q  <= 1'b0;
				sp_q     <= '0;
			end
			if (is_new) begin
				qlen_q <= '0;
			end
			if (is_qchar && qlen_q < QLW'(MAX_QUERY)) begin
				qlen_q <= qlen_q + QLW'(1);
			end
			if (is_nchar) begin
				if (CALC_W'(nl_q) < CALC_W'(MAX_NAME_LEN)) begin
					nl_q <= nl_q + NLW'(1);
					if (prefix_miss) begin
						prefix_q <= 1'b0;
					end
				end
				if (tail_hit) begin
					found_q <= 1'b1;
				end
				if (sp_adv) begin
					sp_q <= sp_q + QLW'(1);
				end
			end
			if (is_end || is_emit) begin
				n_q <= n_now;
				k_q <= '0;
				i_q <= '0;
			end
			if (is_emit && n_now == '0) begin
				strobe_q <= 1'b1;
			end
			if (state_q != ST_IDLE) begin
				k_q <= k_end ? '0 : k_q + SLW'(1);
			end
			if (state_q == ST_SORT_B && k_end) begin
				i_q <= i_q + SLW'(1);
			end
			if (state_q == ST_EMIT) begin
				strobe_q <= 1'b1;
			end
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (is_end) begin
			new_id_q    <= item.entry_id;
			new_score_q <= score[SCORE_W-1:0];
			dup_q       <= 1'b0;
		end
		if (state_q == ST_INS_SCAN) begin
			dup_q         <= scan_dup;
			worst_score_q <= scan_worst;
			if (k_q == '0 || head_less) begin
				worst_q <= k_q;
			end
		end
		if (state_q == ST_SORT_A && (k_q == i_q || (k_q > i_q && head_more))) begin
			carry_q <= head;
		end
		if (is_emit && n_now == '0) begin
			result_q <= '{result_id: '0, result_score: '0, slot_valid: 1'b0, last: 1'b1};
		end
		if (state_q == ST_EMIT) begin
			result_q.slot_valid   <= (head.score != '0);
			result_q.result_id    <= (head.score != '0) ? head.id : '0;
			result_q.result_score <= head.score;
			result_q.last         <= k_end;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

`ifndef SYNTH
	// A result only follows an emit pass or an emit with no slot in use.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> ($past(state_q) == ST_EMIT) ||
			($past(start) && $past(state_q) == ST_IDLE &&
			 $past(item.command) == CMD_EMIT))
		else $error("result strobe without an emit");

	// The subsequence pointer never passes the query length.
	a_subseq: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= qlen_q)
		else $error("subsequence position beyond query");

	// The sort pass index stays below the last slot in use.
	a_sort_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT_A || state_q == ST_SORT_B) |-> (i_q + SLW'(1) < n_q))
		else $error("sort pass index out of range");

	// An insertion write never starts on a duplicate id.
	a_no_dup_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_SCAN && state_d == ST_INS_WRITE) |-> !scan_dup)
		else $error("duplicate id inserted");
`endif

endmodule

[tb/fnst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy name scorer checker
// Watches the command and result channels and predicts every emitted slot.
// Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fnst_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  fnst_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_data,
	input  fnst_pkg::out_item_t result,
	input  logic                result_strobe,
	output int                  errors,
	output int                  pending
);
	import fnst_pkg::*;

	localparam int QCAP  = 64;
	localparam int SLOTS = 32;
	localparam int NCAP  = 255;

	logic [7:0]         qstore [QCAP];
	int                 qlen;
	int                 nlen;
	bit                 prefix_ok;
	logic [QCAP-1:0]    sub_vec;
	bit                 sub_hit;
	int                 seq_pos;
	logic [ID_W-1:0]    ids [SLOTS];
	logic [SCORE_W-1:0] scores [SCORE_W > 0 ? SLOTS : 1];
	logic [5:0]         top_count;
	out_item_t          slots_due [$];

	assign pending = slots_due.size();

	function automatic logic [7:0] fold_case(logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic int used_slots();
		return (top_count > SLOTS) ? SLOTS : int'(top_count);
	endfunction

	task automatic restart_name();
		nlen = 0;
		prefix_ok = 1;
		sub_vec = '0;
		sub_hit = 0;
		seq_pos = 0;
	endtask

	task automatic clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			ids[i] = '0;
			scores[i] = '0;
		end
	endtask

	task automatic track_char(logic [7:0] c);
		bit prev;
		if (nlen < NCAP) begin
			if (nlen < qlen && qstore[nlen] != c)
				prefix_ok = 0;
			nlen++;
		end
		for (int k = qlen - 1; k >= 0; k--) begin
			prev = (k == 0) ? 1'b1 : sub_vec[k-1];
			sub_vec[k] = prev && (qstore[k] == c);
		end
		if (qlen > 0 && sub_vec[qlen-1])
			sub_hit = 1;
		if (seq_pos < qlen && qstore[seq_pos] == c)
			seq_pos++;
	endtask

	function automatic int name_points();
		int bonus;
		int gap;
		if (qlen == 0)
			return 1;
		bonus = 0;
		if (prefix_ok && nlen == qlen)
			bonus = 1000;
		else if (prefix_ok && nlen >= qlen)
			bonus = 300;
		else if (sub_hit)
			bonus = 180;
		else if (seq_pos == qlen)
			bonus = 100;
		gap = nlen - qlen;
		if (gap < 0)
			gap = -gap;
		return bonus - gap;
	endfunction

	task automatic place_entry(logic [ID_W-1:0] id, int pts);
		int n;
		int worst;
		n = used_slots();
		worst = 0;
		if (pts <= 0 || n == 0)
			return;
		for (int i = 0; i < n; i++)
			if (scores[i] > 0 && ids[i] == id)
				return;
		for (int i = 1; i < n; i++)
			if (scores[i] < scores[worst])
				worst = i;
		if (pts > scores[worst]) begin
			ids[worst] = id;
			scores[worst] = pts[SCORE_W-1:0];
		end
	endtask

	task automatic rank_and_emit();
		int n;
		logic [ID_W-1:0] tid;
		logic [SCORE_W-1:0] tsc;
		out_item_t o;
		n = used_slots();
		if (n == 0) begin
			o = '0;
			o.last = 1'b1;
			slots_due.push_back(o);
			return;
		end
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++)
				if (scores[j] > scores[i]) begin
					tsc = scores[i]; scores[i] = scores[j]; scores[j] = tsc;
					tid = ids[i]; ids[i] = ids[j]; ids[j] = tid;
				end
		for (int k = 0; k < n; k++) begin
			o.slot_valid   = scores[k] > 0;
			o.result_id    = o.slot_valid ? ids[k] : '0;
			o.result_score = o.slot_valid ? scores[k] : '0;
			o.last         = (k == n - 1);
			slots_due.push_back(o);
		end
	endtask

	task automatic apply_command(in_item_t it);
		logic [7:0] c;
		c = fold_case(it.character);
		case (it.command)
			CMD_NEW_QUERY: begin
				qlen = 0;
				clear_table();
				restart_name();
			end
			CMD_QUERY_CHAR: begin
				if (qlen < QCAP) begin
					qstore[qlen] = c;
					qlen++;
				end
				restart_name();
			end
			CMD_NAME_CHAR: track_char(c);
			CMD_END_NAME: begin
				place_entry(it.entry_id, name_points());
				restart_name();
			end
			CMD_EMIT: rank_and_emit();
			default: ;
		endcase
	endtask

	task automatic compare_slot(out_item_t got);
		out_item_t want;
		if (slots_due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected result id=%0d score=%0d valid=%0b last=%0b",
					$realtime, got.result_id, got.result_score, got.slot_valid, got.last);
			return;
		end
		want = slots_due.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t: result mismatch: expected id=%0d score=%0d valid=%0b last=%0b, got id=%0d score=%0d valid=%0b last=%0b",
					$realtime, want.result_id, want.result_score, want.slot_valid,
					want.last, got.result_id, got.result_score, got.slot_valid, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			qlen = 0;
			top_count = '0;
			for (int i = 0; i < QCAP; i++)
				qstore[i] = '0;
			clear_table();
			restart_name();
			slots_due.delete();
		end else begin
			// Results of earlier transactions are checked before this edge's command.
			if (result_strobe)
				compare_slot(result);
			if (cfg_we)
				top_count = cfg_data;
			if (start && !busy)
				apply_command(item);
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy name scorer testbench
// Loads queries, streams scored names and emits the ranked table under
// several slot counts and sender idle patterns; a checker predicts results.
// ----------------------------------------------------------------------------
module tb_top;
	import fnst_pkg::*;

	// Command codes that the block must ignore.
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int         PHASE_ITEMS  = 20;
	localparam int         SETTLE       = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_data = '0;
	out_item_t   result;
	logic        result_strobe;
	int          errors;
	int          pending;

	// The test keeps its own copy of the loaded query to build matching names.
	logic [7:0]  query_chars [$];
	int          idle_pct;
	int          sent;

	always #6 clk = ~clk;

	fuzzy_name_scorer_top_k DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result(result),
		.result_strobe(result_strobe)
	);

	fnst_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result(result),
		.result_strobe(result_strobe), .errors(errors), .pending(pending)
	);

	// Drives one transaction and returns once it is accepted and busy is low. The start
	// line stays high so back-to-back transactions follow without a gap.
	task automatic send(logic [2:0] cmd, logic [7:0] ch, logic [15:0] id);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= '{command: cmd, character: ch, entry_id: id};
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// Randomly raises the case of letters so that case folding is exercised.
	function automatic logic [7:0] mix_case(logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 1))
			return c - 8'd32;
		return c;
	endfunction

	// Waits until every predicted slot has appeared and the block is idle,
	// then writes the slot count.
	task automatic set_slots(logic [5:0] n);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic new_query(int len);
		logic [7:0] c;
		send(CMD_NEW_QUERY, 8'($urandom), 16'($urandom));
		query_chars.delete();
		for (int i = 0; i < len; i++) begin
			c = "a" + 8'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0)
				c = "a" + 8'($urandom_range(0, 25));
			send(CMD_QUERY_CHAR, mix_case(c), 16'($urandom));
			if (query_chars.size() < 64)
				query_chars.push_back(c);
		end
	endtask

	task automatic send_name(logic [7:0] chars [$], logic [15:0] id);
		foreach (chars[i])
			send(CMD_NAME_CHAR, mix_case(chars[i]), 16'($urandom));
		send(CMD_END_NAME, 8'($urandom), id);
	endtask

	// Builds a name related to the query in one of several ways: exact,
	// extended prefix, embedded substring, scattered subsequence or unrelated.
	task automatic random_name();
		logic [7:0] nm [$];
		logic [15:0] id;
		int kind;
		kind = $urandom_range(0, 5);
		id = $urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom);
		case (kind)
			0: nm = query_chars;
			1: begin
				nm = query_chars;
				repeat ($urandom_range(1, 4)) nm.push_back("a" + 8'($urandom_range(0, 25)));
			end
			2: begin
				repeat ($urandom_range(1, 3)) nm.push_back("a" + 8'($urandom_range(0, 4)));
				foreach (query_chars[i]) nm.push_back(query_chars[i]);
				repeat ($urandom_range(0, 3)) nm.push_back("a" + 8'($urandom_range(0, 4)));
			end
			3: foreach (query_chars[i]) begin
				nm.push_back(query_chars[i]);
				if ($urandom_range(0, 1)) nm.push_back("a" + 8'($urandom_range(0, 4)));
			end
			default: repeat ($urandom_range(0, 8)) nm.push_back("a" + 8'($urandom_range(0, 4)));
		endcase
		send_name(nm, id);
	endtask

	task automatic random_phase(logic [5:0] slots, int pct);
		int stop;
		int r;
		set_slots(slots);
		idle_pct = pct;
		stop = sent + PHASE_ITEMS;
		while (sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				new_query($urandom_range(0, 29) == 0 ? $urandom_range(64, 68)
					: $urandom_range(0, 6));
			else if (r < 12)
				send(CMD_QUERY_CHAR, 8'($urandom), 16'($urandom));
			else if (r < 19)
				send(CMD_EMIT, 8'($urandom), 16'($urandom));
			else if (r < 22)
				send(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom),
					16'($urandom));
			else if (r < 27)
				send(CMD_NAME_CHAR, 8'($urandom), 16'($urandom));
			else
				random_name();
		end
		send(CMD_EMIT, 8'h00, 16'h0000);
	endtask

	task automatic directed_part();
		logic [7:0] nm [$];
		idle_pct = 0;
		set_slots(6'd4);
		send(CMD_NEW_QUERY, 8'hFF, 16'hFFFF);
		send(CMD_QUERY_CHAR, "A", 16'h0000);
		send(CMD_QUERY_CHAR, "b", 16'h0000);
		send(CMD_QUERY_CHAR, "C", 16'h0000);
		// A name one character past the length limit: the count must saturate, which
		// shows up in the score of the emitted slot.
		nm = '{"a", "b", "c"};
		repeat (253) nm.push_back("q");
		send_name(nm, 16'd7);
		send(CMD_EMIT, 8'd0, 16'd0);
		nm = '{"a", "b", "c"};           send_name(nm, 16'd1);     // exact
		nm = '{"a", "b", "c", "d"};      send_name(nm, 16'd2);     // prefix
		nm = '{"x", "a", "b", "c"};      send_name(nm, 16'hFFFF);  // substring
		nm = '{"a", "x", "b", "c"};      send_name(nm, 16'd0);     // subsequence
		nm = '{"z", "z", "z", "z"};      send_name(nm, 16'd5);     // no match
		nm = '{"a", "b", "c"};           send_name(nm, 16'd1);     // same id again
		send(CMD_SPARE_LO, 8'h41, 16'd9);
		send(CMD_SPARE_HI, 8'h41, 16'd9);
		send(CMD_NAME_CHAR, "a", 16'd0);
		send(CMD_QUERY_CHAR, "d", 16'd0);                           // query change mid-name
		send(CMD_EMIT, 8'd0, 16'd0);
		send(CMD_NEW_QUERY, 8'd0, 16'd0);
		send(CMD_EMIT, 8'd0, 16'd0);                                // all slots empty
		send(CMD_END_NAME, 8'd0, 16'hABCD);                         // empty query scores one
		send(CMD_EMIT, 8'd0, 16'd0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_phase(6'd32, 0);
		random_phase(6'd0, 68);
		random_phase(6'd1, 7);
		random_phase(6'd5, 68);
		random_phase(6'd63, 0);
		random_phase(6'd40, 7);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Long emits sort all 32 slots; this bound
	// leaves room even if every transaction were such an emit.
	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
